>>> rtl/gfcpm_pkg.sv
// Shared types and constants for the gated frequency counter with pulse mimic.
// Used by the top level, the shared multiply/divide unit and the checker.
// No dependencies.
`default_nettype none

package gfcpm_pkg;

   // Fixed field widths.
   localparam int TPS_WIDTH   = 30;
   localparam int FREQ_WIDTH  = 32;
   localparam int TIMER_WIDTH = 32;
   localparam int CSR_IDX_W   = 2;

   // Reset values of the configuration registers.
   localparam logic [TPS_WIDTH-1:0]   TPS_RESET   = 30'd1000;
   localparam logic [TIMER_WIDTH-1:0] GATE_RESET  = 32'd1000;
   localparam logic [TIMER_WIDTH-1:0] BLINK_RESET = 32'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICKS_PER_SECOND = 2'd0,
      CSR_GATE_TICKS       = 2'd1,
      CSR_BLINK_TICKS      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic gate_event;
      logic signal_event;
   } req_type;

   typedef struct packed {
      logic                  led;
      logic [FREQ_WIDTH-1:0] frequency;
      logic                  frequency_new;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MEASURE,
      ST_PERIOD,
      ST_FINISH
   } state_type;

   typedef enum logic {
      OP_MULDIV,
      OP_DIV
   } unit_op_type;

   typedef enum logic [1:0] {
      U_IDLE,
      U_MUL,
      U_DIV
   } unit_state_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [FREQ_WIDTH-1:0] quotient;
   } unit_status_type;

endpackage

`default_nettype wire

>>> rtl/gfcpm_muldiv.sv
// Shared serial arithmetic unit: shift-add multiply then restoring division,
// or division alone, with a 32-bit saturated quotient. Depends on gfcpm_pkg.
`default_nettype none

module gfcpm_muldiv import gfcpm_pkg::*; #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire unit_cmd_type           cmd,
   input  wire logic [COUNT_WIDTH-1:0] op_a,
   input  wire logic [TPS_WIDTH-1:0]   op_b,
   input  wire logic [FREQ_WIDTH-1:0]  op_d,
   output unit_status_type             status
);

   localparam int PW    = COUNT_WIDTH + TPS_WIDTH;
   localparam int CNT_W = $clog2(PW);

   unit_state_type         ustate_ff, ustate_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [PW-1:0]          acc_ff, acc_in;
   logic [TPS_WIDTH-1:0]   mlt_ff, mlt_in;
   logic [COUNT_WIDTH-1:0] a_ff, a_in;
   logic [FREQ_WIDTH-1:0]  d_ff, d_in;
   logic [FREQ_WIDTH-1:0]  rem_ff, rem_in;
   logic [FREQ_WIDTH-1:0]  q_ff, q_in;
   logic                   sat_ff, sat_in;
   logic                   done_ff, done_in;

   logic [FREQ_WIDTH:0]    trial;
   logic                   fits;

   // One restoring-division step on the next dividend bit.
   assign trial = {rem_ff, acc_ff[PW-1]};
   assign fits  = trial >= {1'b0, d_ff};

   always_comb begin
      ustate_in = ustate_ff;
      case (ustate_ff)
         U_IDLE: begin
            if (cmd.start) begin
               ustate_in = (cmd.op == OP_MULDIV) ? U_MUL : U_DIV;
            end
         end
         U_MUL: begin
            if (cnt_ff == '0) begin
               ustate_in = U_DIV;
            end
         end
         U_DIV: begin
            if (cnt_ff == '0) begin
               ustate_in = U_IDLE;
            end
         end
         default: ustate_in = U_IDLE;
      endcase
   end

   always_comb begin
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mlt_in  = mlt_ff;
      a_in    = a_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      case (ustate_ff)
         U_IDLE: begin
            if (cmd.start) begin
               a_in   = op_a;
               mlt_in = op_b;
               d_in   = op_d;
               rem_in = '0;
               q_in   = '0;
               sat_in = 1'b0;
               cnt_in = CNT_W'(TPS_WIDTH - 1);
               if (cmd.op == OP_MULDIV) begin
                  acc_in = '0;
               end else begin
                  acc_in = {op_b, {COUNT_WIDTH{1'b0}}};
               end
            end
         end
         U_MUL: begin
            acc_in = {acc_ff[PW-2:0], 1'b0}
                     + (mlt_ff[TPS_WIDTH-1] ? PW'(a_ff) : '0);
            mlt_in = {mlt_ff[TPS_WIDTH-2:0], 1'b0};
            cnt_in = (cnt_ff == '0) ? CNT_W'(PW - 1) : cnt_ff - 1'b1;
         end
         U_DIV: begin
            rem_in = fits ? FREQ_WIDTH'(trial - {1'b0, d_ff})
                          : trial[FREQ_WIDTH-1:0];
            q_in   = {q_ff[FREQ_WIDTH-2:0], fits};
            // A quotient bit at weight 2^32 or above means overflow.
            sat_in = sat_ff | (fits && (cnt_ff >= CNT_W'(FREQ_WIDTH)));
            acc_in = {acc_ff[PW-2:0], 1'b0};
            if (cnt_ff == '0) begin
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ustate_ff <= U_IDLE;
         done_ff   <= 1'b0;
      end else begin
         ustate_ff <= ustate_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mlt_ff <= mlt_in;
      a_ff   <= a_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = sat_ff ? '1 : q_ff;

endmodule

`default_nettype wire

>>> rtl/gated_frequency_counter_pulse_mimic.sv
// Top level of the gated frequency counter with pulse mimic.
// Depends on gfcpm_pkg and gfcpm_muldiv.
//
// Each input transfer is one time tick carrying a gate event and a signal
// event, and each tick produces exactly one output transfer with the LED
// level, the last measured frequency and a flag that marks a fresh
// measurement. While idle, a gate event opens a window of gate_ticks ticks;
// signal events count from the opening tick up to, but not including, the
// closing tick, saturating at the counter maximum. At the close the block
// publishes count * ticks_per_second / gate_ticks (saturated to 32 bits) and,
// while that frequency is nonzero, blinks the LED once every
// ticks_per_second / frequency ticks, each blink lasting
// min(blink_ticks, period / 2) ticks. Zero register values act as one.
// The block takes one tick at a time. A plain tick passes through accept,
// then hand-off to the output register. A tick in which a pulse is due also
// runs a 30-step division and waits for the unit to report done.
// A tick that closes a window runs the shared serial unit for a 30-step
// multiply and a (COUNT_WIDTH + 30)-step division and waits for done, then
// the period division when the result is nonzero. The one multiply/divide
// unit works one bit per cycle; a stalled result holds back the hand-off.
// The result sits in an output register, so the next tick is accepted while
// the previous result still waits to be taken. Configuration writes are
// always ready and must arrive while idle.
`default_nettype none

module gated_frequency_counter_pulse_mimic import gfcpm_pkg::*; #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]           csr_wdata
);

   // Configuration registers.
   logic [TPS_WIDTH-1:0]   tps_ff, tps_in;
   logic [TIMER_WIDTH-1:0] gate_ff, gate_in;
   logic [TIMER_WIDTH-1:0] blink_ff, blink_in;

   // Counter and pulse state.
   state_type              state_ff, state_in;
   logic                   counting_ff, counting_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [TIMER_WIDTH-1:0] window_ff, window_in;
   logic [FREQ_WIDTH-1:0]  freq_ff, freq_in;
   logic [TIMER_WIDTH-1:0] pulse_left_ff, pulse_left_in;
   logic                   pulse_pend_ff, pulse_pend_in;
   logic                   led_ff, led_in;
   logic [TIMER_WIDTH-1:0] off_left_ff, off_left_in;
   logic                   off_pend_ff, off_pend_in;
   logic                   publish_ff, publish_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // Shared unit hookup.
   unit_cmd_type           ucmd;
   unit_status_type        ustat;
   logic [FREQ_WIDTH-1:0]  unit_d;

   // Per-tick helper terms.
   logic                   accept;
   logic                   slot_free;
   logic [TPS_WIDTH-1:0]   tps1;
   logic [TIMER_WIDTH-1:0] gate1;
   logic [TIMER_WIDTH-1:0] blink1;
   logic [TIMER_WIDTH-1:0] off_left_dec;
   logic                   off_due;
   logic [TIMER_WIDTH-1:0] pulse_left_dec;
   logic                   fire;
   logic [TIMER_WIDTH-1:0] window_dec;
   logic                   close_win;
   logic                   counting_after;
   logic                   q_nonzero;
   logic [TIMER_WIDTH-1:0] period;
   logic [TIMER_WIDTH-1:0] half_period;
   logic [TIMER_WIDTH-1:0] on_time;
   logic [TIMER_WIDTH-1:0] off_load;

   gfcpm_muldiv #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .cmd    (ucmd),
      .op_a   (count_ff),
      .op_b   (tps1),
      .op_d   (unit_d),
      .status (ustat)
   );

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Registers that read as zero behave as one.
   assign tps1   = (tps_ff == '0) ? TPS_WIDTH'(1) : tps_ff;
   assign gate1  = (gate_ff == '0) ? TIMER_WIDTH'(1) : gate_ff;
   assign blink1 = (blink_ff == '0) ? TIMER_WIDTH'(1) : blink_ff;

   // Timer bookkeeping for the tick being accepted: the LED-off timer first,
   // then the pulse timer, then the counting window.
   assign off_left_dec   = (off_left_ff != '0) ? off_left_ff - 1'b1 : '0;
   assign off_due        = off_pend_ff && (off_left_dec == '0);
   assign pulse_left_dec = (pulse_left_ff != '0) ? pulse_left_ff - 1'b1 : '0;
   assign fire           = pulse_pend_ff && (pulse_left_dec == '0);
   assign window_dec     = (window_ff != '0) ? window_ff - 1'b1 : '0;
   assign close_win      = counting_ff && (window_dec == '0);
   assign counting_after = counting_ff && !close_win;

   // Pulse period and LED on time from the period division.
   assign q_nonzero   = ustat.quotient != '0;
   assign period      = q_nonzero ? ustat.quotient : TIMER_WIDTH'(1);
   assign half_period = period >> 1;
   assign on_time     = (half_period < blink1) ? half_period : blink1;
   assign off_load    = (on_time == '0) ? TIMER_WIDTH'(1) : on_time;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (close_win) begin
                  state_in = ST_MEASURE;
               end else if (fire && (freq_ff != '0)) begin
                  state_in = ST_PERIOD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MEASURE: begin
            if (ustat.done) begin
               state_in = q_nonzero ? ST_PERIOD : ST_FINISH;
            end
         end
         ST_PERIOD: begin
            if (ustat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake and unit launch.
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      ucmd.start = 1'b0;
      ucmd.op    = OP_DIV;
      unit_d     = freq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && close_win) begin
               ucmd.start = 1'b1;
               ucmd.op    = OP_MULDIV;
               unit_d     = gate1;
            end else if (accept && fire && (freq_ff != '0)) begin
               ucmd.start = 1'b1;
            end
         end
         ST_MEASURE: begin
            // The period division uses the frequency just measured.
            unit_d = ustat.quotient;
            if (ustat.done && q_nonzero) begin
               ucmd.start = 1'b1;
            end
         end
         default: begin
            ucmd.start = 1'b0;
         end
      endcase
   end

   assign csr_ready = 1'b1;

   // Configuration writes.
   always_comb begin
      tps_in   = tps_ff;
      gate_in  = gate_ff;
      blink_in = blink_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_TICKS_PER_SECOND: tps_in   = csr_wdata[TPS_WIDTH-1:0];
            CSR_GATE_TICKS:       gate_in  = csr_wdata;
            CSR_BLINK_TICKS:      blink_in = csr_wdata;
            default:              tps_in   = tps_ff;
         endcase
      end
   end

   // Datapath.
   always_comb begin
      counting_in   = counting_ff;
      count_in      = count_ff;
      window_in     = window_ff;
      freq_in       = freq_ff;
      pulse_left_in = pulse_left_ff;
      pulse_pend_in = pulse_pend_ff;
      led_in        = led_ff;
      off_left_in   = off_left_ff;
      off_pend_in   = off_pend_ff;
      publish_in    = publish_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (off_pend_ff) begin
                  off_left_in = off_left_dec;
                  if (off_due) begin
                     led_in      = 1'b0;
                     off_pend_in = 1'b0;
                  end
               end
               if (pulse_pend_ff) begin
                  pulse_left_in = pulse_left_dec;
                  if (fire) begin
                     pulse_pend_in = 1'b0;
                  end
               end
               if (counting_ff) begin
                  window_in = window_dec;
                  if (close_win) begin
                     counting_in = 1'b0;
                  end else if (req_data.signal_event && !(&count_ff)) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               // A gate in the closing tick reopens at once; the unit has
               // already captured the closing count.
               if (!counting_after && req_data.gate_event) begin
                  counting_in = 1'b1;
                  count_in    = req_data.signal_event ? COUNT_WIDTH'(1) : '0;
                  window_in   = gate1;
               end
               publish_in = close_win;
            end
         end
         ST_MEASURE: begin
            if (ustat.done) begin
               freq_in = ustat.quotient;
               // A zero measurement stops pulsing.
               if (!q_nonzero) begin
                  pulse_pend_in = 1'b0;
               end
            end
         end
         ST_PERIOD: begin
            if (ustat.done) begin
               led_in        = 1'b1;
               pulse_left_in = period;
               pulse_pend_in = 1'b1;
               off_left_in   = off_load;
               off_pend_in   = 1'b1;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.led           = led_ff;
               rsp_data_in.frequency     = freq_ff;
               rsp_data_in.frequency_new = publish_ff;
            end
         end
         default: begin
            rsp_data_in = rsp_data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff        <= TPS_RESET;
         gate_ff       <= GATE_RESET;
         blink_ff      <= BLINK_RESET;
         state_ff      <= ST_IDLE;
         counting_ff   <= 1'b0;
         count_ff      <= '0;
         window_ff     <= '0;
         freq_ff       <= '0;
         pulse_left_ff <= '0;
         pulse_pend_ff <= 1'b0;
         led_ff        <= 1'b0;
         off_left_ff   <= '0;
         off_pend_ff   <= 1'b0;
         publish_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tps_ff        <= tps_in;
         gate_ff       <= gate_in;
         blink_ff      <= blink_in;
         state_ff      <= state_in;
         counting_ff   <= counting_in;
         count_ff      <= count_in;
         window_ff     <= window_in;
         freq_ff       <= freq_in;
         pulse_left_ff <= pulse_left_in;
         pulse_pend_ff <= pulse_pend_in;
         led_ff        <= led_in;
         off_left_ff   <= off_left_in;
         off_pend_ff   <= off_pend_in;
         publish_ff    <= publish_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/gfcpm_checker.sv
// Port-level checker for the gated frequency counter with pulse mimic,
// bound to the top level. Depends on gfcpm_pkg.
`default_nettype none

module gfcpm_checker import gfcpm_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // The block stalls input in the cycle after each tick's transfer.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted in back-to-back cycles");

   // A fresh nonzero measurement always raises the LED in that tick.
   a_led_on_publish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frequency_new && (rsp_data.frequency != '0))
      |-> rsp_data.led)
      else $error("nonzero measurement published without LED raise");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

   // A result leaves only through a transfer.
   a_rsp_leave: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> !$past(rsp_stall))
      else $error("result withdrawn while stalled");

endmodule

bind gated_frequency_counter_pulse_mimic gfcpm_checker u_gfcpm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
